[design/assert_macros.svh]
// Assertion macros for the design files; the engine unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[design/bse_pkg.sv]
// Types and constants of the basis sifting engine.
package bse_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int PTR_W = $clog2(TABLE_DEPTH + 1);
	localparam int BYTE_W = 8;
	localparam int FILL_W = $clog2(BYTE_W);
	localparam int POS_W = 32;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_SIFT  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_CHECK
	} state_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             basis;
		logic             raw_bit;
	} entry_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} table_req_t;

endpackage

[design/bse_table.sv]
// Raw entry table: one write port, one registered read port.
module bse_table (
	input  logic                clk,
	input  bse_pkg::table_req_t req,
	output bse_pkg::entry_t     rd_data
);

	bse_pkg::entry_t mem [bse_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

[design/basis_sifting_engine_unit.sv]
// Basis sifting engine: raw key table, peer sift walk and byte packer.
//
// Usage:
//   A command transaction is taken at a rising edge with start high and busy low.
//   opcode selects load raw entry, sift with a peer item, or clear the table.
//   Each command gives one result, held on status, matched, byte_valid,
//   key_byte and table_count for the single cycle in which done is high.
//   The receiver cannot stall; done is a one-cycle strobe.
// Timing:
//   Load, clear and the unused opcode: done in the cycle after acceptance,
//   busy stays low, so one command per cycle.
//   Sift: the walk reads the table entries from the walk pointer on, one per
//   cycle through the single table read port, until a hit or the table end;
//   no entry is read when the walk is already at the table end. busy is high
//   until the result cycle, in which the next command may be taken.
// Reset:
//   arst_n clears the entry count, both pointers and the partial byte.
//   The table memory itself has no reset; only entries below the count are read.
module basis_sifting_engine_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   opcode,
	input  logic [bse_pkg::POS_W-1:0]    position,
	input  logic                         basis,
	input  logic                         raw_bit,
	input  logic                         last,
	output logic                         done,
	output logic [1:0]                   status,
	output logic                         matched,
	output logic                         byte_valid,
	output logic [bse_pkg::BYTE_W-1:0]   key_byte,
	output logic [bse_pkg::PTR_W-1:0]    table_count
);

	localparam logic [bse_pkg::PTR_W-1:0] FULL_COUNT = bse_pkg::PTR_W'(bse_pkg::TABLE_DEPTH);
	localparam logic [bse_pkg::FILL_W-1:0] LAST_FILL = bse_pkg::FILL_W'(bse_pkg::BYTE_W - 1);

	bse_pkg::state_t state_q, state_d;

	logic [bse_pkg::PTR_W-1:0]  total_q, total_d;
	logic [bse_pkg::PTR_W-1:0]  walk_q, walk_d;
	logic [bse_pkg::PTR_W-1:0]  keep_q, keep_d;
	logic [bse_pkg::BYTE_W-1:0] shift_q, shift_d;
	logic [bse_pkg::FILL_W-1:0] fill_q, fill_d;

	logic [bse_pkg::POS_W-1:0]  pos_q;
	logic                       basis_q;
	logic                       last_q;

	logic                       done_q, done_d;
	bse_pkg::status_t           status_q, status_d;
	logic                       matched_q, matched_d;
	logic                       byte_valid_q, byte_valid_d;
	logic [bse_pkg::BYTE_W-1:0] key_byte_q, key_byte_d;

	bse_pkg::table_req_t        req;
	bse_pkg::entry_t            rd_data;

	logic accept;
	logic more;
	logic hit;
	logic finish;
	logic found;

	assign accept = start && (state_q == bse_pkg::S_IDLE);
	assign more   = walk_q < total_q;
	assign hit    = rd_data.position == pos_q;

	bse_table u_table (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bse_pkg::S_IDLE: begin
				if (accept && (bse_pkg::opcode_t'(opcode) == bse_pkg::OP_SIFT)) begin
					state_d = bse_pkg::S_WALK;
				end
			end
			bse_pkg::S_WALK: begin
				state_d = more ? bse_pkg::S_CHECK : bse_pkg::S_IDLE;
			end
			bse_pkg::S_CHECK: begin
				if (hit || !more) begin
					state_d = bse_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bse_pkg::S_IDLE;
			end
		endcase
	end

	// datapath control
	always_comb begin
		req          = '0;
		total_d      = total_q;
		walk_d       = walk_q;
		keep_d       = keep_q;
		shift_d      = shift_q;
		fill_d       = fill_q;
		done_d       = 1'b0;
		status_d     = bse_pkg::ST_OK;
		matched_d    = 1'b0;
		byte_valid_d = 1'b0;
		key_byte_d   = '0;
		finish       = 1'b0;
		found        = 1'b0;

		case (state_q)
			bse_pkg::S_IDLE: begin
				if (accept) begin
					case (bse_pkg::opcode_t'(opcode))
						bse_pkg::OP_LOAD: begin
							done_d = 1'b1;
							if (total_q == FULL_COUNT) begin
								status_d = bse_pkg::ST_FULL;
							end else begin
								req.wr_en   = 1'b1;
								req.wr_addr = total_q[bse_pkg::ADDR_W-1:0];
								req.wr_data = '{position: position, basis: basis,
									raw_bit: raw_bit};
								total_d     = total_q + 1'b1;
							end
						end
						bse_pkg::OP_SIFT: begin
						end
						bse_pkg::OP_CLEAR: begin
							done_d  = 1'b1;
							total_d = '0;
							walk_d  = '0;
							keep_d  = '0;
							shift_d = '0;
							fill_d  = '0;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			bse_pkg::S_WALK: begin
				if (more) begin
					req.rd_en   = 1'b1;
					req.rd_addr = walk_q[bse_pkg::ADDR_W-1:0];
					walk_d      = walk_q + 1'b1;
				end else begin
					finish = 1'b1;
				end
			end
			bse_pkg::S_CHECK: begin
				if (hit) begin
					finish = 1'b1;
					found  = 1'b1;
				end else if (more) begin
					req.rd_en   = 1'b1;
					req.rd_addr = walk_q[bse_pkg::ADDR_W-1:0];
					walk_d      = walk_q + 1'b1;
				end else begin
					finish = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (finish) begin
			done_d = 1'b1;
			if (!found) begin
				status_d = bse_pkg::ST_MISS;
			end
			if (found && (rd_data.basis == basis_q)) begin
				matched_d   = 1'b1;
				req.wr_en   = 1'b1;
				req.wr_addr = keep_q[bse_pkg::ADDR_W-1:0];
				req.wr_data = rd_data;
				keep_d      = keep_q + 1'b1;
				shift_d     = {shift_q[bse_pkg::BYTE_W-2:0], rd_data.raw_bit};
				fill_d      = fill_q + 1'b1;
				if (fill_q == LAST_FILL) begin
					byte_valid_d = 1'b1;
					key_byte_d   = {shift_q[bse_pkg::BYTE_W-2:0], rd_data.raw_bit};
					shift_d      = '0;
				end
			end
			if (last_q) begin
				total_d = keep_d;
				walk_d  = '0;
				keep_d  = '0;
				shift_d = '0;
				fill_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bse_pkg::S_IDLE;
			total_q  <= '0;
			walk_q   <= '0;
			keep_q   <= '0;
			shift_q  <= '0;
			fill_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			total_q  <= total_d;
			walk_q   <= walk_d;
			keep_q   <= keep_d;
			shift_q  <= shift_d;
			fill_q   <= fill_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q   <= position;
			basis_q <= basis;
			last_q  <= last;
		end
		status_q     <= status_d;
		matched_q    <= matched_d;
		byte_valid_q <= byte_valid_d;
		key_byte_q   <= key_byte_d;
	end

	assign busy        = state_q != bse_pkg::S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign matched     = matched_q;
	assign byte_valid  = byte_valid_q;
	assign key_byte    = key_byte_q;
	assign table_count = total_q;

`include "assert_macros.svh"

	`ASSERT_CLK(a_keep_behind_walk, clk, arst_n, keep_q <= walk_q, "keep pointer passed walk pointer")
	`ASSERT_CLK(a_walk_in_table, clk, arst_n, walk_q <= total_q, "walk pointer beyond table end")
	`ASSERT_CLK(a_count_in_range, clk, arst_n, total_q <= FULL_COUNT, "table count beyond depth")
	`ASSERT_CLK(a_short_cmd_done, clk, arst_n, accept && (opcode != bse_pkg::OP_SIFT) |=> done_q && !busy, "short command gave no result")
	`ASSERT_CLK(a_byte_needs_match, clk, arst_n, byte_valid_q |-> matched_q && done_q, "byte emitted without a match")

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Testbench of the basis sifting engine: directed table, then random sift rounds against a predictor.
module tb_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1400;
	localparam logic [bse_pkg::POS_W-1:0] POS_MAX = 32'hFFFF_FFFF;
	localparam logic [bse_pkg::POS_W-1:0] BASE_CEIL = 32'hF000_0000;

	typedef struct packed {
		bse_pkg::status_t           status;
		logic                       matched;
		logic                       byte_valid;
		logic [bse_pkg::BYTE_W-1:0] key_byte;
		logic [bse_pkg::PTR_W-1:0]  table_count;
	} sift_result_t;

	typedef struct packed {
		logic [1:0]                op;
		logic [bse_pkg::POS_W-1:0] position;
		logic                      basis;
		logic                      raw_bit;
		logic                      last;
		logic                      typed;
		sift_result_t              res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] opcode = bse_pkg::OP_LOAD;
	logic [bse_pkg::POS_W-1:0] position = '0;
	logic basis = 1'b0;
	logic raw_bit = 1'b0;
	logic last = 1'b0;
	logic busy;
	logic done;
	logic [1:0] status;
	logic matched;
	logic byte_valid;
	logic [bse_pkg::BYTE_W-1:0] key_byte;
	logic [bse_pkg::PTR_W-1:0] table_count;

	basis_sifting_engine_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.position(position),
		.basis(basis),
		.raw_bit(raw_bit),
		.last(last),
		.done(done),
		.status(status),
		.matched(matched),
		.byte_valid(byte_valid),
		.key_byte(key_byte),
		.table_count(table_count)
	);

	// predictor copy of the raw key table and the round state
	logic [bse_pkg::POS_W-1:0] key_pos [bse_pkg::TABLE_DEPTH];
	logic key_basis [bse_pkg::TABLE_DEPTH];
	logic key_bit [bse_pkg::TABLE_DEPTH];
	int unsigned key_total = 0;
	int unsigned walk_idx = 0;
	int unsigned keep_idx = 0;
	int unsigned fill_cnt = 0;
	logic [bse_pkg::BYTE_W-1:0] shift_reg = '0;

	sift_result_t pending_q[$];
	stim_row_t dir_rows[$];
	int errors = 0;
	int n_items = 0;
	int n_load = 0;
	int n_sift = 0;
	int n_bytes = 0;
	int n_full = 0;
	int n_miss = 0;
	int burst_left = 0;
	logic [bse_pkg::POS_W-1:0] next_pos = '0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic stim_row_t plain_row(logic [1:0] op, logic [bse_pkg::POS_W-1:0] pos,
			logic b, logic rb, logic lst);
		stim_row_t s;
		s = '0;
		s.op = op;
		s.position = pos;
		s.basis = b;
		s.raw_bit = rb;
		s.last = lst;
		return s;
	endfunction

	// typed rows carry no match and no byte, only a status and a count
	function automatic stim_row_t typed_row(logic [1:0] op, logic [bse_pkg::POS_W-1:0] pos,
			logic b, logic rb, logic lst, bse_pkg::status_t st,
			logic [bse_pkg::PTR_W-1:0] cnt);
		stim_row_t s;
		s = plain_row(op, pos, b, rb, lst);
		s.typed = 1'b1;
		s.res.status = st;
		s.res.table_count = cnt;
		return s;
	endfunction

	function automatic sift_result_t sift_predict(logic [1:0] op,
			logic [bse_pkg::POS_W-1:0] pos, logic b, logic rb, logic lst);
		sift_result_t r;
		bit found;
		int unsigned w;
		r = '0;
		found = 1'b0;
		case (op)
		bse_pkg::OP_LOAD: begin
			if (key_total >= bse_pkg::TABLE_DEPTH) begin
				r.status = bse_pkg::ST_FULL;
			end else begin
				key_pos[key_total] = pos;
				key_basis[key_total] = b;
				key_bit[key_total] = rb;
				key_total++;
			end
		end
		bse_pkg::OP_SIFT: begin
			while (!found && walk_idx < key_total) begin
				w = walk_idx;
				walk_idx++;
				if (key_pos[w] == pos) begin
					found = 1'b1;
					if (key_basis[w] == b) begin
						key_pos[keep_idx] = key_pos[w];
						key_basis[keep_idx] = key_basis[w];
						key_bit[keep_idx] = key_bit[w];
						keep_idx++;
						r.matched = 1'b1;
						shift_reg = {shift_reg[bse_pkg::BYTE_W-2:0], key_bit[w]};
						fill_cnt++;
						if (fill_cnt == bse_pkg::BYTE_W) begin
							r.byte_valid = 1'b1;
							r.key_byte = shift_reg;
							shift_reg = '0;
							fill_cnt = 0;
						end
					end
				end
			end
			if (!found)
				r.status = bse_pkg::ST_MISS;
			if (lst) begin
				key_total = keep_idx;
				walk_idx = 0;
				keep_idx = 0;
				shift_reg = '0;
				fill_cnt = 0;
			end
		end
		bse_pkg::OP_CLEAR: begin
			key_total = 0;
			walk_idx = 0;
			keep_idx = 0;
			shift_reg = '0;
			fill_cnt = 0;
		end
		default: ;
		endcase
		r.table_count = key_total[bse_pkg::PTR_W-1:0];
		return r;
	endfunction

	// drive one command, hold it until taken, then log what it should produce
	task automatic issue_cmd(logic [1:0] op, logic [bse_pkg::POS_W-1:0] pos, logic b,
			logic rb, logic lst, logic typed = 1'b0, sift_result_t typed_res = '0);
		sift_result_t r;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 9));
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = int'($urandom_range(1, 24));
		end
		start <= 1'b1;
		opcode <= op;
		position <= pos;
		basis <= b;
		raw_bit <= rb;
		last <= lst;
		@(posedge clk);
		while (busy) @(posedge clk);
		burst_left--;
		r = sift_predict(op, pos, b, rb, lst);
		if (typed)
			r = typed_res;
		pending_q.push_back(r);
		if (op != OP_UNUSED)
			n_items++;
		if (op == bse_pkg::OP_LOAD)
			n_load++;
		if (op == bse_pkg::OP_SIFT)
			n_sift++;
		if (r.byte_valid)
			n_bytes++;
		if (r.status == bse_pkg::ST_FULL)
			n_full++;
		if (r.status == bse_pkg::ST_MISS)
			n_miss++;
	endtask

	task automatic drain_results();
		int cycles;
		cycles = 0;
		start <= 1'b0;
		do begin
			@(posedge clk);
			cycles++;
		end while (pending_q.size() != 0 && cycles < 300000);
	endtask

	// optionally clear, load a run of entries, then announce an ordered subset of the table as the peer list
	task automatic sift_round(bit fresh, int n_loads, int max_step, int keep_pct);
		logic [bse_pkg::POS_W-1:0] peer_pos [$];
		logic peer_basis [$];
		logic [bse_pkg::POS_W-1:0] p;
		int cut;
		int roll;
		if (fresh || key_total == 0 || next_pos > BASE_CEIL || $urandom_range(0, 99) < 25) begin
			issue_cmd(bse_pkg::OP_CLEAR, $urandom, rand_bit(), rand_bit(), rand_bit());
			next_pos = $urandom_range(0, BASE_CEIL);
		end
		repeat (n_loads) begin
			if ($urandom_range(0, 99) < 3)
				issue_cmd(OP_UNUSED, $urandom, rand_bit(), rand_bit(), rand_bit());
			next_pos += $urandom_range(1, max_step);
			issue_cmd(bse_pkg::OP_LOAD, next_pos, rand_bit(), rand_bit(), rand_bit());
		end
		for (int j = int'(walk_idx); j < int'(key_total); j++) begin
			if ($urandom_range(0, 99) < keep_pct) begin
				peer_pos.push_back(key_pos[j]);
				peer_basis.push_back(($urandom_range(0, 99) < 70) ? key_basis[j] : !key_basis[j]);
			end
		end
		if (peer_pos.size() == 0) begin
			if (key_total > 0)
				peer_pos.push_back(key_pos[key_total-1]);
			else
				peer_pos.push_back($urandom);
			peer_basis.push_back(rand_bit());
		end
		cut = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, peer_pos.size()))
			: peer_pos.size();
		for (int i = 0; i < cut; i++) begin
			roll = int'($urandom_range(0, 99));
			if (roll < 3) begin
				next_pos += $urandom_range(1, max_step);
				issue_cmd(bse_pkg::OP_LOAD, next_pos, rand_bit(), rand_bit(), rand_bit());
			end else if (roll < 5) begin
				issue_cmd(OP_UNUSED, $urandom, rand_bit(), rand_bit(), rand_bit());
			end else if (roll < 6) begin
				issue_cmd(bse_pkg::OP_CLEAR, $urandom, rand_bit(), rand_bit(), rand_bit());
			end
			p = ($urandom_range(0, 99) < 4) ? $urandom : peer_pos[i];
			issue_cmd(bse_pkg::OP_SIFT, p, peer_basis[i], rand_bit(), i == cut - 1);
		end
	endtask

	always @(posedge clk) begin
		sift_result_t exp_r;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$error("unexpected transaction: status %0d table_count %0d", status, table_count);
				errors++;
			end else begin
				exp_r = pending_q.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					errors++;
				end
				if (matched !== exp_r.matched) begin
					$error("matched: expected %0d, got %0d", exp_r.matched, matched);
					errors++;
				end
				if (byte_valid !== exp_r.byte_valid) begin
					$error("byte_valid: expected %0d, got %0d", exp_r.byte_valid, byte_valid);
					errors++;
				end
				if (key_byte !== exp_r.key_byte) begin
					$error("key_byte: expected 0x%02h, got 0x%02h", exp_r.key_byte, key_byte);
					errors++;
				end
				if (table_count !== exp_r.table_count) begin
					$error("table_count: expected %0d, got %0d", exp_r.table_count, table_count);
					errors++;
				end
			end
		end
	end

	initial begin
		bit full_done;
		stim_row_t row;
		full_done = 1'b0;

		// empty table after reset, unused opcode
		dir_rows.push_back(typed_row(bse_pkg::OP_SIFT, 32'h0, 1'b0, 1'b0, 1'b0,
			bse_pkg::ST_MISS, 11'd0));
		dir_rows.push_back(typed_row(bse_pkg::OP_SIFT, POS_MAX, 1'b1, 1'b1, 1'b1,
			bse_pkg::ST_MISS, 11'd0));
		dir_rows.push_back(typed_row(OP_UNUSED, POS_MAX, 1'b1, 1'b1, 1'b1,
			bse_pkg::ST_OK, 11'd0));
		// raw entries 0..8 and the top position
		dir_rows.push_back(typed_row(bse_pkg::OP_LOAD, 32'd0, 1'b0, 1'b1, 1'b0,
			bse_pkg::ST_OK, 11'd1));
		dir_rows.push_back(typed_row(bse_pkg::OP_LOAD, 32'd1, 1'b1, 1'b0, 1'b0,
			bse_pkg::ST_OK, 11'd2));
		dir_rows.push_back(typed_row(bse_pkg::OP_LOAD, 32'd2, 1'b0, 1'b1, 1'b1,
			bse_pkg::ST_OK, 11'd3));
		dir_rows.push_back(typed_row(bse_pkg::OP_LOAD, 32'd3, 1'b1, 1'b1, 1'b0,
			bse_pkg::ST_OK, 11'd4));
		dir_rows.push_back(typed_row(bse_pkg::OP_LOAD, 32'd4, 1'b0, 1'b0, 1'b0,
			bse_pkg::ST_OK, 11'd5));
		dir_rows.push_back(typed_row(bse_pkg::OP_LOAD, 32'd5, 1'b1, 1'b0, 1'b0,
			bse_pkg::ST_OK, 11'd6));
		dir_rows.push_back(typed_row(bse_pkg::OP_LOAD, 32'd6, 1'b0, 1'b1, 1'b0,
			bse_pkg::ST_OK, 11'd7));
		dir_rows.push_back(typed_row(bse_pkg::OP_LOAD, 32'd7, 1'b1, 1'b0, 1'b0,
			bse_pkg::ST_OK, 11'd8));
		dir_rows.push_back(typed_row(bse_pkg::OP_LOAD, 32'd8, 1'b0, 1'b1, 1'b0,
			bse_pkg::ST_OK, 11'd9));
		dir_rows.push_back(typed_row(bse_pkg::OP_LOAD, POS_MAX, 1'b1, 1'b1, 1'b0,
			bse_pkg::ST_OK, 11'd10));
		// basis mismatch, a skipped entry, then enough matches for one byte on the last item
		dir_rows.push_back(plain_row(bse_pkg::OP_SIFT, 32'd0, 1'b1, 1'b0, 1'b0));
		dir_rows.push_back(plain_row(bse_pkg::OP_SIFT, 32'd2, 1'b0, 1'b0, 1'b0));
		dir_rows.push_back(plain_row(bse_pkg::OP_SIFT, 32'd3, 1'b1, 1'b0, 1'b0));
		dir_rows.push_back(plain_row(bse_pkg::OP_SIFT, 32'd4, 1'b0, 1'b0, 1'b0));
		dir_rows.push_back(plain_row(bse_pkg::OP_SIFT, 32'd5, 1'b1, 1'b0, 1'b0));
		dir_rows.push_back(plain_row(bse_pkg::OP_SIFT, 32'd6, 1'b0, 1'b0, 1'b0));
		dir_rows.push_back(plain_row(bse_pkg::OP_SIFT, 32'd7, 1'b1, 1'b0, 1'b0));
		dir_rows.push_back(plain_row(bse_pkg::OP_SIFT, 32'd8, 1'b0, 1'b0, 1'b0));
		dir_rows.push_back(plain_row(bse_pkg::OP_SIFT, POS_MAX, 1'b1, 1'b0, 1'b1));
		// position already passed: walk runs off the end, rest of the round misses
		dir_rows.push_back(plain_row(bse_pkg::OP_SIFT, 32'd5, 1'b1, 1'b0, 1'b0));
		dir_rows.push_back(typed_row(bse_pkg::OP_SIFT, 32'd4, 1'b0, 1'b0, 1'b0,
			bse_pkg::ST_MISS, 11'd8));
		dir_rows.push_back(plain_row(bse_pkg::OP_SIFT, 32'd8, 1'b0, 1'b0, 1'b1));
		dir_rows.push_back(typed_row(bse_pkg::OP_CLEAR, POS_MAX, 1'b1, 1'b1, 1'b1,
			bse_pkg::ST_OK, 11'd0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			issue_cmd(row.op, row.position, row.basis, row.raw_bit, row.last, row.typed, row.res);
		end
		drain_results();

		while (n_items < dir_rows.size() + RANDOM_ITEMS) begin
			if (!full_done && n_items > 200) begin
				// let the pipe empty, then fill the table past its depth
				drain_results();
				sift_round(1'b1, bse_pkg::TABLE_DEPTH + 3, 1000, 3);
				full_done = 1'b1;
			end else begin
				sift_round(1'b0, int'($urandom_range(1, 40)),
					($urandom_range(0, 1) == 0) ? 4 : 32'h0040_0000,
					int'($urandom_range(40, 95)));
			end
		end

		drain_results();
		if (pending_q.size() != 0) begin
			$error("%0d expected transactions never arrived", pending_q.size());
			errors++;
		end
		repeat (32) @(posedge clk);

		$display("Ran %0d commands: %0d loads, %0d peer sifts, %0d key bytes emitted",
			n_items, n_load, n_sift, n_bytes);
		$display("Table-full loads: %0d, peer positions not found: %0d, mismatches: %0d",
			n_full, n_miss, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[basis_sifting_engine_unit.f]
+incdir+design
design/bse_pkg.sv
design/bse_table.sv
design/basis_sifting_engine_unit.sv
test/tb_top.sv
